>>> sv/ppauq_pkg.sv
// ----------------------------------------------------------------------------
// ppauq_pkg
// Shared types and constants for the ping-pong active user queue.
// ----------------------------------------------------------------------------
package ppauq_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 256;
  localparam int unsigned ID_W            = 16;
  localparam int unsigned TS_W            = 32;
  localparam int unsigned NUM_BINS        = 5;
  localparam int unsigned BIN_W           = $clog2(NUM_BINS);
  localparam int unsigned NUM_EDGES       = 4;
  localparam int unsigned CFG_IDX_W       = $clog2(NUM_EDGES);

  // Reset values of the histogram bin edges, in nanoseconds, edge 3 first.
  localparam logic [NUM_EDGES-1:0][TS_W-1:0] EDGE_RESET = {
    32'd20000000, 32'd15000000, 32'd11000000, 32'd9000000
  };

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_POP    = 2'd1,
    REQ_LOCK   = 2'd2,
    REQ_UNLOCK = 2'd3
  } ppauq_req_e;

  // Per-transaction result flags from the queue control.
  typedef struct packed {
    logic pop_valid;
    logic add_dropped;
  } ppauq_flags_t;

endpackage

>>> sv/ppauq_store.sv
// ----------------------------------------------------------------------------
// ppauq_store
// Shared user id storage for both queues, one write and one read port.
// ----------------------------------------------------------------------------
module ppauq_store
  import ppauq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  localparam int unsigned AW = $clog2(2 * QUEUE_DEPTH)
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [AW-1:0]   waddr_i,
  input  logic [ID_W-1:0] wdata_i,
  input  logic            re_i,
  input  logic [AW-1:0]   raddr_i,
  output logic [ID_W-1:0] rdata_o
);

  logic [ID_W-1:0] mem [2 * QUEUE_DEPTH];
  logic [ID_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read data holds until the next pop.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/ppauq_queue_ctrl.sv
// ----------------------------------------------------------------------------
// ppauq_queue_ctrl
// Head/tail/count bookkeeping for the two queues, role swap and lock flag.
// ----------------------------------------------------------------------------
module ppauq_queue_ctrl
  import ppauq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  localparam int unsigned AW    = $clog2(2 * QUEUE_DEPTH),
  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH),
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  ppauq_req_e       req_i,
  input  logic             queue_sel_i,
  output logic             we_o,
  output logic [AW-1:0]    waddr_o,
  output logic             re_o,
  output logic [AW-1:0]    raddr_o,
  output ppauq_flags_t     flags_o,
  output logic [CNT_W-1:0] current_count_o,
  output logic [CNT_W-1:0] next_count_o,
  output logic             locked_o
);

  logic [PTR_W-1:0] head_q [2];
  logic [PTR_W-1:0] head_d [2];
  logic [PTR_W-1:0] tail_q [2];
  logic [PTR_W-1:0] tail_d [2];
  logic [CNT_W-1:0] cnt_q  [2];
  logic [CNT_W-1:0] cnt_d  [2];
  logic             cur_q, cur_d;
  logic             locked_q, locked_d;
  logic             add_buf, pop_buf;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [AW-1:0] addr_of(input logic b, input logic [PTR_W-1:0] p);
    return AW'(p) + (b ? AW'(QUEUE_DEPTH) : '0);
  endfunction

  assign add_buf = locked_q ? ~cur_q : cur_q;
  assign pop_buf = queue_sel_i ? ~cur_q : cur_q;
  assign waddr_o = addr_of(add_buf, tail_q[add_buf]);
  assign raddr_o = addr_of(pop_buf, head_q[pop_buf]);

  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    cnt_d    = cnt_q;
    cur_d    = cur_q;
    locked_d = locked_q;
    we_o     = 1'b0;
    re_o     = 1'b0;
    flags_o  = '0;
    if (accept_i) begin
      case (req_i)
        REQ_ADD: begin
          if (cnt_q[add_buf] == CNT_W'(QUEUE_DEPTH)) begin
            flags_o.add_dropped = 1'b1;
          end else begin
            we_o            = 1'b1;
            tail_d[add_buf] = ptr_next(tail_q[add_buf]);
            cnt_d[add_buf]  = cnt_q[add_buf] + 1'b1;
          end
        end
        REQ_POP: begin
          if (cnt_q[pop_buf] != '0) begin
            re_o              = 1'b1;
            flags_o.pop_valid = 1'b1;
            head_d[pop_buf]   = ptr_next(head_q[pop_buf]);
            cnt_d[pop_buf]    = cnt_q[pop_buf] - 1'b1;
          end
        end
        REQ_LOCK: begin
          locked_d = 1'b1;
        end
        REQ_UNLOCK: begin
          head_d[cur_q] = '0;
          tail_d[cur_q] = '0;
          cnt_d[cur_q]  = '0;
          cur_d         = ~cur_q;
          locked_d      = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '{default: '0};
      tail_q   <= '{default: '0};
      cnt_q    <= '{default: '0};
      cur_q    <= 1'b0;
      locked_q <= 1'b0;
    end else begin
      head_q   <= head_d;
      tail_q   <= tail_d;
      cnt_q    <= cnt_d;
      cur_q    <= cur_d;
      locked_q <= locked_d;
    end
  end

  assign current_count_o = cnt_q[cur_q];
  assign next_count_o    = cnt_q[~cur_q];
  assign locked_o        = locked_q;

endmodule

>>> sv/ppauq_lock_stats.sv
// ----------------------------------------------------------------------------
// ppauq_lock_stats
// Bin edge registers, lock-to-lock interval histogram and maximum interval.
// ----------------------------------------------------------------------------
module ppauq_lock_stats
  import ppauq_pkg::*;
(
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [CFG_IDX_W-1:0]           cfg_index_i,
  input  logic [TS_W-1:0]                cfg_data_i,
  input  logic                           lock_i,
  input  logic [TS_W-1:0]                now_i,
  output logic [TS_W-1:0]                max_o,
  output logic [NUM_BINS-1:0][TS_W-1:0]  hist_o
);

  logic [NUM_EDGES-1:0][TS_W-1:0] edge_q;
  logic [TS_W-1:0]                last_q, last_d;
  logic [TS_W-1:0]                max_q, max_d;
  logic [NUM_BINS-1:0][TS_W-1:0]  hist_q, hist_d;
  logic [TS_W-1:0]                diff;
  logic [BIN_W-1:0]               bin;
  logic                           armed;

  assign diff  = now_i - last_q;
  assign armed = (max_q != '0);

  always_comb begin
    if (diff < edge_q[0])      bin = BIN_W'(0);
    else if (diff < edge_q[1]) bin = BIN_W'(1);
    else if (diff < edge_q[2]) bin = BIN_W'(2);
    else if (diff < edge_q[3]) bin = BIN_W'(3);
    else                       bin = BIN_W'(4);
  end

  always_comb begin
    last_d = last_q;
    max_d  = max_q;
    hist_d = hist_q;
    if (lock_i) begin
      last_d = now_i;
      if (!armed) begin
        max_d = TS_W'(1);
      end else begin
        if (diff > max_q) max_d = diff;
        for (int i = 0; i < NUM_BINS; i++) begin
          if (bin == BIN_W'(i)) hist_d[i] = hist_q[i] + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_q <= EDGE_RESET;
      last_q <= '0;
      max_q  <= '0;
      hist_q <= '0;
    end else begin
      if (cfg_we_i) edge_q[cfg_index_i] <= cfg_data_i;
      last_q <= last_d;
      max_q  <= max_d;
      hist_q <= hist_d;
    end
  end

  assign max_o  = max_q;
  assign hist_o = hist_q;

endmodule

>>> sv/ping_pong_active_user_queue.sv
// ----------------------------------------------------------------------------
// ping_pong_active_user_queue
// Double-buffered user id queue with lock-interval histogram.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (in_valid_i/in_ready_o): add, pop, lock or unlock, one
//   transaction per cycle while in_ready_o is high. Every request gives
//   exactly one result transaction on out_valid_o/out_ready_i, in the cycle
//   after acceptance. Throughput is one request per cycle: all queue pointers,
//   counters and histogram state update at the accepting edge, and the pop
//   data comes from the single registered read port of the id store.
//   Status outputs (counts, lock flag, max interval, bins) are driven straight
//   from the state registers; queue, lock and histogram state only moves when
//   a new request is taken, which happens only when the result register is
//   empty or being drained. A stalled receiver therefore holds the result and
//   back-pressures in_ready_o, while an idle one lets a request in every cycle.
//   Config channel (cfg_*): always ready, writes one bin edge register.
//   Reset: both queues empty, buffer zero current, unlocked, histogram and
//   max interval zero, edges at their defaults. Store contents are left
//   undefined; no clearing pass is needed since pops only read written slots.
// ----------------------------------------------------------------------------
module ping_pong_active_user_queue
  import ppauq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  localparam int unsigned AW    = $clog2(2 * QUEUE_DEPTH),
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // request channel
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           req_type_i,
  input  logic [ID_W-1:0]      user_id_i,
  input  logic                 queue_sel_i,
  input  logic [TS_W-1:0]      now_ns_i,
  // result channel
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 pop_valid_o,
  output logic [ID_W-1:0]      popped_user_o,
  output logic                 add_dropped_o,
  output logic [CNT_W-1:0]     current_count_o,
  output logic [CNT_W-1:0]     next_count_o,
  output logic                 locked_flag_o,
  output logic [TS_W-1:0]      longest_interval_o,
  output logic [TS_W-1:0]      hist_bin_zero_o,
  output logic [TS_W-1:0]      hist_bin_one_o,
  output logic [TS_W-1:0]      hist_bin_two_o,
  output logic [TS_W-1:0]      hist_bin_three_o,
  output logic [TS_W-1:0]      hist_bin_four_o,
  // configuration channel
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [TS_W-1:0]      cfg_data_i
);

  logic                          accept;
  ppauq_req_e                    req;
  logic                          we, re;
  logic [AW-1:0]                 waddr, raddr;
  logic [ID_W-1:0]               rdata;
  ppauq_flags_t                  flags, flags_q;
  logic                          out_valid_q, out_valid_d;
  logic [NUM_BINS-1:0][TS_W-1:0] hist;

  // Result register frees up as soon as the receiver takes it.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign req        = ppauq_req_e'(req_type_i);
  assign cfg_ready_o = 1'b1;

  ppauq_queue_ctrl #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .req_i           (req),
    .queue_sel_i     (queue_sel_i),
    .we_o            (we),
    .waddr_o         (waddr),
    .re_o            (re),
    .raddr_o         (raddr),
    .flags_o         (flags),
    .current_count_o (current_count_o),
    .next_count_o    (next_count_o),
    .locked_o        (locked_flag_o)
  );

  ppauq_store #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (user_id_i),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  ppauq_lock_stats u_stats (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .lock_i      (accept && (req == REQ_LOCK)),
    .now_i       (now_ns_i),
    .max_o       (longest_interval_o),
    .hist_o      (hist)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // flags are payload: loaded with every accepted request
  always_ff @(posedge clk_i) begin
    if (accept) flags_q <= flags;
  end

  assign out_valid_o      = out_valid_q;
  assign pop_valid_o      = flags_q.pop_valid;
  assign add_dropped_o    = flags_q.add_dropped;
  assign popped_user_o    = flags_q.pop_valid ? rdata : '0;
  assign hist_bin_zero_o  = hist[0];
  assign hist_bin_one_o   = hist[1];
  assign hist_bin_two_o   = hist[2];
  assign hist_bin_three_o = hist[3];
  assign hist_bin_four_o  = hist[4];

`ifndef SYNTH
  // lock always leaves the block locked
  a_lock_sets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (req == REQ_LOCK) |=> locked_flag_o)
    else $error("lock did not set locked flag");

  // unlock always clears the lock and empties the new next queue
  a_unlock_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (req == REQ_UNLOCK) |=> !locked_flag_o && (next_count_o == '0))
    else $error("unlock did not clear state");

  // an add that is not dropped grows the total occupancy by one
  a_add_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (req == REQ_ADD) |=> add_dropped_o ||
      (({1'b0, current_count_o} + {1'b0, next_count_o}) ==
       ($past({1'b0, current_count_o} + {1'b0, next_count_o}) + 1'b1)))
    else $error("add did not update occupancy");
`endif

endmodule
